FILE: rtl/core/tqcr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tqcr_pkg
// shared constants and types for the three queue replacement block
// ----------------------------------------------------------------------------
package tqcr_pkg;

    localparam int NUM_SETS   = 64;
    localparam int WAYS       = 8;
    localparam int TAG_BITS   = 32;
    localparam int STAMP_BITS = 32;
    localparam int SET_W      = $clog2(NUM_SETS);
    localparam int WAY_W      = $clog2(WAYS);
    localparam int CNT_W      = $clog2(WAYS + 1);
    localparam int CAP_W      = 3;
    localparam int CMD_W      = 2;
    localparam int FREQ_MAX   = 3;

    // per way: queue(2) freq(2) stamp
    localparam int WREC_W = 4 + STAMP_BITS;
    localparam int WROW_W = WAYS * WREC_W;
    localparam int GROW_W = WAYS * TAG_BITS;
    // tag store row: way tags
    localparam int TROW_W = WAYS * TAG_BITS;

    typedef enum logic [1:0] {
        CMD_HIT   = 2'd0,
        CMD_FILL  = 2'd1,
        CMD_INVAL = 2'd2,
        CMD_VICT  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        Q_NONE  = 2'd0,
        Q_SMALL = 2'd1,
        Q_MAIN  = 2'd2,
        Q_RSVD  = 2'd3
    } queue_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_DECIDE,
        ST_SMALL,
        ST_MAIN,
        ST_GHOST,
        ST_WRITE,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [WAY_W-1:0] victim_way;
        logic             victim_valid;
        logic             victim_was_free;
        logic             ghost_hit;
    } result_t;

endpackage

FILE: rtl/core/tqcr_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tqcr_ram
// generic single port ram with registered read
// ----------------------------------------------------------------------------
module tqcr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

FILE: rtl/core/three_queue_cache_replacement.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_queue_cache_replacement
// per set small, main and ghost queue replacement state in on-chip ram
// ----------------------------------------------------------------------------
// channel  dir  handshake          payload
// s_axis   in   tvalid/tready      tdata: cmd, set_index, way, tag
// m_axis   out  tvalid/tready      tdata: victim_way, valid, was_free, ghost_hit
// cfg      in   cfg_we             cfg_data: small_queue_cap
// hit, fill and invalidate pass the read, decide, ghost, write and out states;
// a victim takes a free way if any, else runs the small scan, which promotes
// ways of nonzero frequency to main, and the main scan, which gives second
// chances; the sequencer steps over one set row read from ram. after reset a
// clearing pass sweeps the way and ghost rows of all sets; no item is taken
// meanwhile. one item at a time; an output register holds results until taken.
// ----------------------------------------------------------------------------
module three_queue_cache_replacement (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // cmd[1:0] set_index[7:2] way[10:8] tag[42:11] zeros[47:43]
    input  logic [47:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // victim_way[2:0] victim_valid[3] victim_was_free[4] ghost_hit[5] zeros
    output logic [7:0]  m_axis_tdata
);
    import tqcr_pkg::*;

    state_t state_reg, state_next;
    logic [CAP_W-1:0] cap_reg;
    logic [STAMP_BITS-1:0] stamp_reg, stamp_next;
    logic [SET_W-1:0] set_reg, set_next;
    logic [WAY_W-1:0] way_reg, way_next, vw_reg, vw_next;
    logic [1:0] cmd_reg, cmd_next;
    logic [TAG_BITS-1:0] tag_reg, tag_next, gtag_reg, gtag_next;
    logic ovalid_reg, ovalid_next;
    result_t res_reg, res_next;

    logic [1:0]            q_reg [WAYS];
    logic [1:0]            q_next [WAYS];
    logic [1:0]            f_reg [WAYS];
    logic [1:0]            f_next [WAYS];
    logic [STAMP_BITS-1:0] s_reg [WAYS];
    logic [STAMP_BITS-1:0] s_next [WAYS];
    logic [TAG_BITS-1:0]   g_reg [WAYS];
    logic [TAG_BITS-1:0]   g_next [WAYS];
    logic [CNT_W-1:0]      gc_reg, gc_next;

    logic          w_we, g_we, t_we;
    logic [SET_W-1:0] addr;
    logic [WROW_W-1:0] w_wdata, w_rdata;
    logic [GROW_W+CNT_W-1:0] g_wdata, g_rdata;
    logic [TROW_W-1:0] t_wdata, t_rdata;

    tqcr_ram #(.WIDTH(WROW_W), .DEPTH(NUM_SETS)) u_way_ram (
        .clk(clk), .we(w_we), .addr(addr), .wdata(w_wdata), .rdata(w_rdata));
    tqcr_ram #(.WIDTH(GROW_W + CNT_W), .DEPTH(NUM_SETS)) u_ghost_ram (
        .clk(clk), .we(g_we), .addr(addr), .wdata(g_wdata), .rdata(g_rdata));
    tqcr_ram #(.WIDTH(TROW_W), .DEPTH(NUM_SETS)) u_tag_ram (
        .clk(clk), .we(t_we), .addr(addr), .wdata(t_wdata), .rdata(t_rdata));

    logic [CAP_W-1:0] scap;
    logic [CNT_W-1:0] mcap, scnt, mcnt;
    logic [WAY_W-1:0] free_w, stail, mtail;
    logic free_f, sfound, mfound;
    logic [WAY_W-1:0] gpos;
    logic gfound;

    always_comb
    begin
        scap = cap_reg;
        if (scap < CAP_W'(1))
        begin
            scap = CAP_W'(1);
        end
        if (CNT_W'(scap) > CNT_W'(WAYS - 1))
        begin
            scap = CAP_W'(WAYS - 1);
        end
        mcap = CNT_W'(WAYS) - CNT_W'(scap);
    end

    always_comb
    begin
        free_f = 1'b0;
        free_w = '0;
        scnt = '0;
        mcnt = '0;
        sfound = 1'b0;
        mfound = 1'b0;
        stail = '0;
        mtail = '0;
        for (int i = WAYS - 1; i >= 0; i--)
        begin
            if (q_reg[i] == Q_NONE)
            begin
                free_f = 1'b1;
                free_w = WAY_W'(i);
            end
        end
        for (int i = 0; i < WAYS; i++)
        begin
            if (q_reg[i] == Q_SMALL)
            begin
                scnt = scnt + CNT_W'(1);
                if (!sfound || s_reg[i] < s_reg[stail])
                begin
                    stail = WAY_W'(i);
                end
                sfound = 1'b1;
            end
            if (q_reg[i] == Q_MAIN)
            begin
                mcnt = mcnt + CNT_W'(1);
                if (!mfound || s_reg[i] < s_reg[mtail])
                begin
                    mtail = WAY_W'(i);
                end
                mfound = 1'b1;
            end
        end
    end

    logic [TAG_BITS-1:0] tag_sel;
    logic [TAG_BITS-1:0] way_tags [WAYS];
    always_comb
    begin
        for (int i = 0; i < WAYS; i++)
        begin
            way_tags[i] = t_rdata[i*TAG_BITS +: TAG_BITS];
        end
        tag_sel = (cmd_reg == CMD_VICT) ? gtag_reg : tag_reg;
        gfound = 1'b0;
        gpos = '0;
        for (int i = WAYS - 1; i >= 0; i--)
        begin
            if (CNT_W'(i) < gc_reg && g_reg[i] == tag_sel)
            begin
                gfound = 1'b1;
                gpos = WAY_W'(i);
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < WAYS; i++)
        begin
            w_wdata[i*WREC_W +: WREC_W] = {q_reg[i], f_reg[i], s_reg[i]};
            g_wdata[i*TAG_BITS +: TAG_BITS] = g_reg[i];
            t_wdata[i*TAG_BITS +: TAG_BITS] = way_tags[i];
        end
        g_wdata[GROW_W +: CNT_W] = gc_reg;
        if (state_reg == ST_CLEAR)
        begin
            w_wdata = '0;
            g_wdata = '0;
        end
        if (cmd_reg == CMD_FILL && state_reg == ST_WRITE)
        begin
            t_wdata[way_reg*TAG_BITS +: TAG_BITS] = tag_reg;
        end
    end

    logic [STAMP_BITS-1:0] stamp_inc;
    assign stamp_inc = stamp_reg + STAMP_BITS'(1);

    always_comb
    begin
        state_next = state_reg;
        stamp_next = stamp_reg;
        set_next = set_reg;
        way_next = way_reg;
        cmd_next = cmd_reg;
        tag_next = tag_reg;
        gtag_next = gtag_reg;
        vw_next = vw_reg;
        ovalid_next = ovalid_reg;
        res_next = res_reg;
        q_next = q_reg;
        f_next = f_reg;
        s_next = s_reg;
        g_next = g_reg;
        gc_next = gc_reg;
        w_we = 1'b0;
        g_we = 1'b0;
        t_we = 1'b0;
        addr = set_reg;
        s_axis_tready = 1'b0;
        if (ovalid_reg && m_axis_tready)
        begin
            ovalid_next = 1'b0;
        end
        unique case (state_reg)
            ST_CLEAR:
            begin
                for (int i = 0; i < WAYS; i++)
                begin
                    q_next[i] = Q_NONE;
                    f_next[i] = '0;
                    s_next[i] = '0;
                end
                gc_next = '0;
                w_we = 1'b1;
                g_we = 1'b1;
                set_next = set_reg + SET_W'(1);
                if (set_reg == SET_W'(NUM_SETS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                s_axis_tready = !ovalid_reg;
                if (s_axis_tvalid && !ovalid_reg)
                begin
                    cmd_next = s_axis_tdata[1:0];
                    set_next = SET_W'(s_axis_tdata[7:2]);
                    way_next = s_axis_tdata[10:8];
                    tag_next = s_axis_tdata[42:11];
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                for (int i = 0; i < WAYS; i++)
                begin
                    {q_next[i], f_next[i], s_next[i]} = w_rdata[i*WREC_W +: WREC_W];
                    g_next[i] = g_rdata[i*TAG_BITS +: TAG_BITS];
                end
                gc_next = g_rdata[GROW_W +: CNT_W];
                res_next = '0;
                state_next = (cmd_reg == CMD_VICT) ? ST_SMALL : ST_GHOST;
            end
            ST_SMALL:
            begin
                if (free_f)
                begin
                    vw_next = free_w;
                    res_next.victim_was_free = 1'b1;
                    state_next = ST_WRITE;
                end
                else if (CNT_W'(scnt) >= CNT_W'(scap) && sfound)
                begin
                    if (f_reg[stail] == 2'd0)
                    begin
                        vw_next = stail;
                        gtag_next = way_tags[stail];
                        state_next = ST_GHOST;
                    end
                    else
                    begin
                        f_next[stail] = f_reg[stail] - 2'd1;
                        q_next[stail] = Q_MAIN;
                        s_next[stail] = stamp_inc;
                        stamp_next = stamp_inc;
                        if (mcnt + CNT_W'(1) >= mcap)
                        begin
                            state_next = ST_MAIN;
                        end
                    end
                end
                else
                begin
                    state_next = ST_MAIN;
                end
            end
            ST_MAIN:
            begin
                if (!mfound || f_reg[mtail] == 2'd0)
                begin
                    vw_next = mtail;
                    state_next = ST_WRITE;
                end
                else
                begin
                    f_next[mtail] = f_reg[mtail] - 2'd1;
                    s_next[mtail] = stamp_inc;
                    stamp_next = stamp_inc;
                end
            end
            ST_GHOST:
            begin
                state_next = ST_WRITE;
                if (cmd_reg == CMD_VICT)
                begin
                    // remove if present, push at head, trim
                    for (int i = 1; i < WAYS; i++)
                    begin
                        if (!gfound || WAY_W'(i) <= gpos)
                        begin
                            g_next[i] = g_reg[i-1];
                        end
                    end
                    g_next[0] = gtag_reg;
                    if (!gfound)
                    begin
                        gc_next = (gc_reg >= CNT_W'(WAYS)) ? CNT_W'(WAYS) :
                                  gc_reg + CNT_W'(1);
                    end
                    if (gc_next > mcap)
                    begin
                        gc_next = mcap;
                    end
                end
                else if (way_reg < WAY_W'(WAYS) || WAYS == (1 << WAY_W))
                begin
                    unique case (cmd_t'(cmd_reg))
                        CMD_HIT:
                        begin
                            if (q_reg[way_reg] != Q_NONE && f_reg[way_reg] != 2'(FREQ_MAX))
                            begin
                                f_next[way_reg] = f_reg[way_reg] + 2'd1;
                            end
                        end
                        CMD_FILL:
                        begin
                            f_next[way_reg] = '0;
                            s_next[way_reg] = stamp_inc;
                            stamp_next = stamp_inc;
                            if (gfound)
                            begin
                                q_next[way_reg] = Q_MAIN;
                                res_next.ghost_hit = 1'b1;
                                for (int i = 0; i < WAYS - 1; i++)
                                begin
                                    if (WAY_W'(i) >= gpos)
                                    begin
                                        g_next[i] = g_reg[i+1];
                                    end
                                end
                                gc_next = gc_reg - CNT_W'(1);
                            end
                            else
                            begin
                                q_next[way_reg] = Q_SMALL;
                            end
                        end
                        default:
                        begin
                            q_next[way_reg] = Q_NONE;
                            f_next[way_reg] = '0;
                            s_next[way_reg] = '0;
                        end
                    endcase
                end
            end
            ST_WRITE:
            begin
                w_we = 1'b1;
                g_we = 1'b1;
                t_we = (cmd_reg == CMD_FILL);
                if (cmd_reg == CMD_VICT)
                begin
                    res_next.victim_way = vw_reg;
                    res_next.victim_valid = 1'b1;
                end
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                ovalid_next = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            cap_reg <= CAP_W'(2);
            stamp_reg <= '0;
            set_reg <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            stamp_reg <= stamp_next;
            set_reg <= set_next;
            ovalid_reg <= ovalid_next;
            if (cfg_we)
            begin
                cap_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        way_reg <= way_next;
        cmd_reg <= cmd_next;
        tag_reg <= tag_next;
        gtag_reg <= gtag_next;
        vw_reg <= vw_next;
        res_reg <= res_next;
        q_reg <= q_next;
        f_reg <= f_next;
        s_reg <= s_next;
        g_reg <= g_next;
        gc_reg <= gc_next;
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata = {2'b00, res_reg.ghost_hit, res_reg.victim_was_free,
                           res_reg.victim_valid, res_reg.victim_way};
endmodule
